// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds on every edge outside reset
`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// consequent holds on the edge after the antecedent
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

// ===== rtl/core/rob_pkg.sv =====
package rob_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_W    = 5;
  localparam int TAG_W    = 5;
  localparam int DATA_W   = 32;

  typedef struct packed {
    logic              load_valid;
    logic [TAG_W-1:0]  load_tag;
    logic [REG_W-1:0]  load_dest;
    logic              bus_valid;
    logic [TAG_W-1:0]  bus_tag;
    logic [DATA_W-1:0] bus_value;
    logic [REG_W-1:0]  query_reg;
  } rob_req_t;

  typedef struct packed {
    logic              commit_valid;
    logic [REG_W-1:0]  commit_dest;
    logic [DATA_W-1:0] commit_value;
    logic              full_res;
    logic              load_dropped;
    logic              query_busy;
    logic [TAG_W-1:0]  query_tag;
  } rob_rsp_t;

  // rename table update: clear on retire, set on load
  typedef struct packed {
    logic             clr_en;
    logic [REG_W-1:0] clr_reg;
    logic [TAG_W-1:0] clr_tag;
    logic             set_en;
    logic [REG_W-1:0] set_reg;
    logic [TAG_W-1:0] set_tag;
  } rename_upd_t;

  typedef struct packed {
    logic             busy;
    logic [TAG_W-1:0] tag;
  } rename_qry_t;

endpackage

// ===== rtl/core/rob_stream_if.sv =====
interface rob_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rob_rename.sv =====
module rob_rename (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [rob_pkg::REG_W-1:0] query_reg,
  output rob_pkg::rename_qry_t  qry,
  input  rob_pkg::rename_upd_t  upd
);
  import rob_pkg::*;

  logic [NUM_REGS-1:0] busy;
  logic [TAG_W-1:0]    tag [NUM_REGS];

  // answered from the table as it stands before this word
  always_comb begin
    qry.busy = busy[query_reg];
    qry.tag  = busy[query_reg] ? tag[query_reg] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        tag[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        // load lands after retire, so its mark wins
        if (upd.set_en && upd.set_reg == REG_W'(i)) begin
          busy[i] <= 1'b1;
          tag[i]  <= upd.set_tag;
        end else if (upd.clr_en && upd.clr_reg == REG_W'(i) && tag[i] == upd.clr_tag) begin
          busy[i] <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/reorder_buffer_commit.sv =====
// Reorder buffer with in-order commit and a 32-entry register rename table.
// Each req word is one machine cycle: a result-bus broadcast, a retire of the
// head entry when it is done, and an optional allocate at the tail. Every req
// word gives exactly one rsp word. A word passes from req to rsp through an
// input register, then single-pass update logic over the entry flops and the
// rename table into the result register, and one word is accepted per cycle
// while rsp keeps up. A stalled rsp holds one result while one more word waits
// in the input register. The query fields reflect the state before the word;
// full_res is the tail state after this word's retire and before its load.
module reorder_buffer_commit #(
  parameter int ENTRIES = 16
) (
  input logic          clk,
  input logic          rst,
  rob_stream_if.sink   req,
  rob_stream_if.source rsp
);
  import rob_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
    return (v == LAST_IDX) ? '0 : v + 1'b1;
  endfunction

  // input register and result register
  logic     s1_valid;
  rob_req_t s1_item;
  logic     s1_fire;
  logic     out_valid;
  rob_rsp_t out_item;
  rob_rsp_t rsp_next;

  // entry storage
  logic [ENTRIES-1:0] active;
  logic [ENTRIES-1:0] done;
  logic [TAG_W-1:0]   tag   [ENTRIES];
  logic [REG_W-1:0]   dest  [ENTRIES];
  logic [DATA_W-1:0]  value [ENTRIES];
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;

  logic [ENTRIES-1:0] bc_hit;
  logic               commit_en;
  logic [DATA_W-1:0]  head_value;
  logic               tail_busy;
  logic               load_en;
  rename_upd_t        upd;
  rename_qry_t        qry;

  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= req.data;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      bc_hit[i] = s1_item.bus_valid && active[i] && tag[i] == s1_item.bus_tag;
    end
    commit_en  = active[head] && (done[head] || bc_hit[head]);
    head_value = bc_hit[head] ? s1_item.bus_value : value[head];
    // a retire this word frees the tail when the buffer was full
    tail_busy  = active[tail] && !(commit_en && head == tail);
    load_en    = s1_item.load_valid && !tail_busy;
  end

  always_comb begin
    upd.clr_en  = s1_fire && commit_en;
    upd.clr_reg = dest[head];
    upd.clr_tag = tag[head];
    upd.set_en  = s1_fire && load_en;
    upd.set_reg = s1_item.load_dest;
    upd.set_tag = s1_item.load_tag;
  end

  rob_rename u_rename (
    .clk       (clk),
    .rst       (rst),
    .query_reg (s1_item.query_reg),
    .qry       (qry),
    .upd       (upd)
  );

  always_comb begin
    rsp_next.commit_valid = commit_en;
    rsp_next.commit_dest  = commit_en ? dest[head] : '0;
    rsp_next.commit_value = commit_en ? head_value : '0;
    rsp_next.full_res     = tail_busy;
    rsp_next.load_dropped = s1_item.load_valid && tail_busy;
    rsp_next.query_busy   = qry.busy;
    rsp_next.query_tag    = qry.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      done   <= '0;
      head   <= '0;
      tail   <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (load_en && tail == IDX_W'(i)) begin
          active[i] <= 1'b1;
          done[i]   <= 1'b0;
        end else if (commit_en && head == IDX_W'(i)) begin
          active[i] <= 1'b0;
          done[i]   <= 1'b0;
        end else if (bc_hit[i]) begin
          done[i] <= 1'b1;
        end
      end
      if (commit_en) begin
        head <= wrap_inc(head);
      end
      if (load_en) begin
        tail <= wrap_inc(tail);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (load_en && tail == IDX_W'(i)) begin
          tag[i]   <= s1_item.load_tag;
          dest[i]  <= s1_item.load_dest;
          value[i] <= '0;
        end else if (bc_hit[i]) begin
          value[i] <= s1_item.bus_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= rsp_next;
    end
  end

`include "assert_macros.svh"

  // live entries run contiguously from head, so an empty head slot at tail means empty
  `ASSERT_PROP(a_empty_ring, clk, rst, (head == tail && !active[head]) |-> active == '0, "entries live outside head..tail")
  `ASSERT_NEXT(a_head_moves, clk, rst, s1_fire && commit_en, head != $past(head), "head did not advance on retire")
  `ASSERT_NEXT(a_tail_moves, clk, rst, s1_fire && load_en, tail != $past(tail) && active[$past(tail)], "allocate did not take the tail")
  `ASSERT_PROP(a_idle_commit, clk, rst, (rsp.valid && !rsp.data.commit_valid) |-> (rsp.data.commit_dest == '0 && rsp.data.commit_value == '0), "commit fields set without retire")

endmodule
